// ----- hdl/dru_pkg.sv -----
// ----------------------------------------------------------------------------
// dru_pkg
// Shared types and constants of the detection row decoder: register codes,
// the configuration bundle, the box request passed from front to back.
// ----------------------------------------------------------------------------
package dru_pkg;

	localparam int MAX_CLASSES_DEF = 128;
	localparam int MAX_ROWS_DEF    = 32768;
	localparam int FIXED_FIELDS    = 5;
	localparam int QUEUE_DEPTH     = 2;

	localparam int VALUE_W    = 32;
	localparam int BOX_W      = 21;
	localparam int CLASS_W    = 7;
	localparam int ROW_W      = 15;
	localparam int CNT_W      = 8;
	localparam int THR_W      = 17;
	localparam int PAD_W      = 12;
	localparam int GAIN_W     = 24;
	localparam int DIFF_W     = 34;
	localparam int OP_W       = 18;
	localparam int PROD_W     = OP_W + GAIN_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CNT_W-1:0]  CLASS_COUNT_RST = 8'd80;
	localparam logic [THR_W-1:0]  CONF_THR_RST    = 17'd29491;
	localparam logic [THR_W-1:0]  SCORE_THR_RST   = 17'd32768;
	localparam logic [PAD_W-1:0]  PAD_RST         = 12'd0;
	localparam logic [GAIN_W-1:0] INV_GAIN_RST    = 24'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLASS_COUNT = 3'd0,
		REG_CONF_THR    = 3'd1,
		REG_SCORE_THR   = 3'd2,
		REG_PAD_X       = 3'd3,
		REG_PAD_Y       = 3'd4,
		REG_INV_GAIN    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0]  class_count;
		logic [THR_W-1:0]  conf_thr;
		logic [THR_W-1:0]  score_thr;
		logic [PAD_W-1:0]  pad_x;
		logic [PAD_W-1:0]  pad_y;
		logic [GAIN_W-1:0] inv_gain;
	} cfg_t;

	typedef struct packed {
		logic [DIFF_W-1:0]  dx;
		logic [DIFF_W-1:0]  dy;
		logic [VALUE_W-1:0] w;
		logic [VALUE_W-1:0] h;
		logic [CLASS_W-1:0] cls;
		logic [VALUE_W-1:0] obj;
		logic [ROW_W-1:0]   row;
	} job_t;

	typedef struct packed {
		logic busy;
		logic last_step;
		logic pop;
	} bk_stat_t;

endpackage

// ----- hdl/dru_queue.sv -----
// ----------------------------------------------------------------------------
// dru_queue
// Small register queue of box requests between the front and the back.
// ----------------------------------------------------------------------------
module dru_queue import dru_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wjob,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rjob
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign rjob  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wjob;
		end
	end

endmodule

// ----- hdl/dru_front.sv -----
// ----------------------------------------------------------------------------
// dru_front
// Takes tensor values, tracks the row position, holds the box fields and the
// running class argmax, and queues a box request for each row that passes.
// ----------------------------------------------------------------------------
module dru_front import dru_pkg::*; #(
	parameter int MaxClasses = MAX_CLASSES_DEF,
	parameter int MaxRows    = MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      tensor_start,
	input  logic                      q_full,
	output logic                      q_push,
	output job_t                      q_job
);
	localparam int PosW = $clog2(MaxClasses + FIXED_FIELDS);
	localparam int RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;

	logic [PosW-1:0]    pos_q;
	logic [RowW-1:0]    row_q;
	logic [VALUE_W-1:0] box_q [4];
	logic [VALUE_W-1:0] obj_q;
	logic [VALUE_W-1:0] best_q;
	logic [CLASS_W-1:0] cls_q;
	logic [DIFF_W-1:0]  dx_q;
	logic [DIFF_W-1:0]  dy_q;

	logic               accept;
	logic [CNT_W:0]     cc_ext;
	logic [CNT_W-1:0]   n_eff;
	logic [PosW-1:0]    last;
	logic [PosW-1:0]    pos;
	logic [RowW-1:0]    row;
	logic [RowW-1:0]    row_next;
	logic [RowW+14:0]   row_wide;
	logic [PosW+6:0]    pm5;
	logic               row_end;
	logic               v_gt;
	logic [VALUE_W-1:0] best_new;
	logic [CLASS_W-1:0] cls_new;
	logic               keep;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;

	always_comb begin
		cc_ext = {1'b0, cfg.class_count};
		if (cfg.class_count == '0) begin
			n_eff = CNT_W'(1);
		end else if (cc_ext > (CNT_W+1)'(MaxClasses)) begin
			n_eff = CNT_W'(MaxClasses);
		end else begin
			n_eff = cfg.class_count;
		end
		last = PosW'(n_eff) + PosW'(FIXED_FIELDS - 1);
	end

	assign pos      = tensor_start ? '0 : pos_q;
	assign row      = tensor_start ? '0 : row_q;
	assign row_end  = (pos >= last);
	assign row_next = (row == RowW'(MaxRows - 1)) ? '0 : row + 1'b1;
	assign row_wide = (RowW+15)'(row);
	assign pm5      = (PosW+7)'(pos) - (PosW+7)'(FIXED_FIELDS);
	assign v_gt     = value > $signed(best_q);

	always_comb begin
		if (pos == PosW'(FIXED_FIELDS)) begin
			best_new = value;
			cls_new  = '0;
		end else if (v_gt) begin
			best_new = value;
			cls_new  = pm5[CLASS_W-1:0];
		end else begin
			best_new = best_q;
			cls_new  = cls_q;
		end
	end

	assign keep = ($signed({obj_q[VALUE_W-1], obj_q}) >= $signed({16'b0, cfg.conf_thr}))
		&& ($signed({best_new[VALUE_W-1], best_new}) > $signed({16'b0, cfg.score_thr}));

	assign q_push = accept && row_end && keep;

	always_comb begin
		q_job.dx  = dx_q;
		q_job.dy  = dy_q;
		q_job.w   = box_q[2];
		q_job.h   = box_q[3];
		q_job.cls = cls_new;
		q_job.obj = obj_q;
		q_job.row = row_wide[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				pos_q <= '0;
				row_q <= row_next;
			end else begin
				pos_q <= pos + 1'b1;
				row_q <= row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos < PosW'(4)) begin
				box_q[pos[1:0]] <= value;
			end else if (pos == PosW'(4)) begin
				obj_q <= value;
				dx_q  <= {box_q[0][VALUE_W-1], box_q[0], 1'b0}
					- {{2{box_q[2][VALUE_W-1]}}, box_q[2]};
				dy_q  <= {box_q[1][VALUE_W-1], box_q[1], 1'b0}
					- {{2{box_q[3][VALUE_W-1]}}, box_q[3]};
			end else begin
				best_q <= best_new;
				cls_q  <= cls_new;
			end
		end
	end

endmodule

// ----- hdl/dru_back.sv -----
// ----------------------------------------------------------------------------
// dru_back
// Turns a box request into image coordinates: corner and size terms, then one
// shared multiplier by the inverse gain over four steps, truncate, saturate.
// ----------------------------------------------------------------------------
module dru_back import dru_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      q_empty,
	input  job_t                      q_head,
	output bk_stat_t                  stat,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [BOX_W-1:0]   box_left,
	output logic signed [BOX_W-1:0]   box_top,
	output logic signed [BOX_W-1:0]   box_width,
	output logic signed [BOX_W-1:0]   box_height,
	output logic [CLASS_W-1:0]        class_index,
	output logic signed [VALUE_W-1:0] objectness,
	output logic [ROW_W-1:0]          row_index
);
	localparam logic [2:0] LAST_STEP = 3'd4;

	function automatic logic [OP_W-1:0] corner_op(input logic [DIFF_W-1:0] d,
			input logic [PAD_W-1:0] pad);
		logic [DIFF_W-1:0] b;
		logic [16:0]       s;
		b = d + (d[DIFF_W-1] ? DIFF_W'(131071) : '0);
		s = b[DIFF_W-1:17];
		return {s[16], s} - {6'b0, pad};
	endfunction

	function automatic logic [OP_W-1:0] size_op(input logic [VALUE_W-1:0] w);
		logic [VALUE_W-1:0] b;
		logic [15:0]        s;
		b = w + (w[VALUE_W-1] ? VALUE_W'(65535) : '0);
		s = b[VALUE_W-1:16];
		return {{2{s[15]}}, s};
	endfunction

	function automatic logic [BOX_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] b;
		logic signed [26:0]       q;
		b = p + (p[PROD_W-1] ? PROD_W'(65535) : '0);
		q = b[PROD_W-1:16];
		if (q > 27'sd1048575) begin
			return 21'h0FFFFF;
		end else if (q < -27'sd1048576) begin
			return 21'h100000;
		end else begin
			return q[BOX_W-1:0];
		end
	endfunction

	logic                     busy_q;
	logic [2:0]               step_q;
	logic signed [OP_W-1:0]   op_q [4];
	logic signed [PROD_W-1:0] prod_s1;
	logic [BOX_W-1:0]         res_q [3];
	logic [CLASS_W-1:0]       cls_q;
	logic [VALUE_W-1:0]       obj_q;
	logic [ROW_W-1:0]         row_q;
	logic                     out_valid_q;

	logic last_step;
	logic out_free;
	logic pop;
	logic finish;

	assign last_step = busy_q && (step_q == LAST_STEP);
	assign out_free  = !out_valid_q || !out_stall;
	assign finish    = last_step && out_free;
	assign pop       = !q_empty && (!busy_q || finish);

	assign stat.busy      = busy_q;
	assign stat.last_step = last_step;
	assign stat.pop       = pop;
	assign out_valid      = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q && !last_step) begin
				step_q <= step_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q[0] <= corner_op(q_head.dx, cfg.pad_x);
			op_q[1] <= corner_op(q_head.dy, cfg.pad_y);
			op_q[2] <= size_op(q_head.w);
			op_q[3] <= size_op(q_head.h);
			cls_q   <= q_head.cls;
			obj_q   <= q_head.obj;
			row_q   <= q_head.row;
		end
		if (busy_q && !last_step) begin
			prod_s1 <= op_q[step_q[1:0]] * $signed({1'b0, cfg.inv_gain});
			if (step_q != '0) begin
				res_q[step_q[1:0] - 2'd1] <= scale_sat(prod_s1);
			end
		end
		if (finish) begin
			box_left    <= res_q[0];
			box_top     <= res_q[1];
			box_width   <= res_q[2];
			box_height  <= scale_sat(prod_s1);
			class_index <= cls_q;
			objectness  <= obj_q;
			row_index   <= row_q;
		end
	end

endmodule

// ----- hdl/detection_row_decode_unit.sv -----
// ----------------------------------------------------------------------------
// detection_row_decode_unit
// Decodes detector output rows into boxes in image pixels.
// ----------------------------------------------------------------------------
// Input channel: one tensor value per request (in_valid / in_stall), rows of
// x, y, w, h, objectness and class_count class scores; tensor_start marks the
// first value of a tensor and restarts the row position and row number.
// Output channel: one box request per kept row (out_valid / out_stall).
// Configuration: cfg_wr_en writes cfg_data into register cfg_index; write only
// while no row is in flight.
// Throughput: one value per cycle. Each box occupies the shared gain
// multiplier of the back part for less time than a row takes to arrive, and
// every row is at least six values long, so the input only stalls when the
// output is held off. A two-entry request queue sits between front and back;
// when the receiver stalls, the output register holds the box, the queue
// fills and in_stall rises once it is full.
// Reset: registers return to their defaults, position and row number clear,
// the queue and the output empty. No clearing pass.
// ----------------------------------------------------------------------------
module detection_row_decode_unit import dru_pkg::*; #(
	parameter int MaxClasses = MAX_CLASSES_DEF,
	parameter int MaxRows    = MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      tensor_start,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [BOX_W-1:0]   box_left,
	output logic signed [BOX_W-1:0]   box_top,
	output logic signed [BOX_W-1:0]   box_width,
	output logic signed [BOX_W-1:0]   box_height,
	output logic [CLASS_W-1:0]        class_index,
	output logic signed [VALUE_W-1:0] objectness,
	output logic [ROW_W-1:0]          row_index
);
	cfg_t     cfg_q;
	logic     q_push;
	logic     q_full;
	logic     q_empty;
	job_t     q_wjob;
	job_t     q_rjob;
	bk_stat_t bstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_count <= CLASS_COUNT_RST;
			cfg_q.conf_thr    <= CONF_THR_RST;
			cfg_q.score_thr   <= SCORE_THR_RST;
			cfg_q.pad_x       <= PAD_RST;
			cfg_q.pad_y       <= PAD_RST;
			cfg_q.inv_gain    <= INV_GAIN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CLASS_COUNT: cfg_q.class_count <= cfg_data[CNT_W-1:0];
				REG_CONF_THR:    cfg_q.conf_thr    <= cfg_data[THR_W-1:0];
				REG_SCORE_THR:   cfg_q.score_thr   <= cfg_data[THR_W-1:0];
				REG_PAD_X:       cfg_q.pad_x       <= cfg_data[PAD_W-1:0];
				REG_PAD_Y:       cfg_q.pad_y       <= cfg_data[PAD_W-1:0];
				REG_INV_GAIN:    cfg_q.inv_gain    <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dru_front #(
		.MaxClasses (MaxClasses),
		.MaxRows    (MaxRows)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.tensor_start (tensor_start),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (q_wjob)
	);

	dru_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wjob   (q_wjob),
		.full   (q_full),
		.pop    (bstat.pop),
		.empty  (q_empty),
		.rjob   (q_rjob)
	);

	dru_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (q_rjob),
		.stat        (bstat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.box_left    (box_left),
		.box_top     (box_top),
		.box_width   (box_width),
		.box_height  (box_height),
		.class_index (class_index),
		.objectness  (objectness),
		.row_index   (row_index)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("box request pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> !q_empty)
		else $error("box request taken from an empty queue");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.pop |-> (!bstat.busy || bstat.last_step))
		else $error("box request taken while the back is occupied");

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(bstat.last_step))
		else $error("box presented without a finished scaling pass");

endmodule
